// ===== sv/integral_image_stream_assert.svh =====
// assertion macros for the integral image block
`ifndef INTEGRAL_IMAGE_STREAM_ASSERT_SVH
`define INTEGRAL_IMAGE_STREAM_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define IIS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define IIS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define IIS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define IIS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== sv/iis_pkg.sv =====
package iis_pkg;

   localparam int AREA_W       = 28;
   localparam int PIXEL_W      = 8;
   localparam int DIM_CFG_W    = 11;
   localparam int CSR_INDEX_W  = 1;

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

   localparam int IMAGE_WIDTH_RESET  = 640;
   localparam int IMAGE_HEIGHT_RESET = 480;

   localparam int QUEUE_DEPTH = 4;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [AREA_W-1:0] area_sum;
      logic              row_end;
      logic              frame_end;
   } result_type;

endpackage

// ===== sv/iis_ram.sv =====
module iis_ram #(
   parameter int WIDTH = 28,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== sv/iis_out_queue.sv =====
module iis_out_queue
   import iis_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  result_type                 push_data,
   output logic                       out_valid,
   output result_type                 out_data,
   input  logic                       out_stall,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   result_type        mem [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              pop;

   assign out_valid = (count_ff != '0);
   assign out_data  = mem[rd_ptr_ff];
   assign count     = count_ff;
   assign pop       = out_valid && !out_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== sv/integral_image_stream.sv =====
// integral image (summed-area table) of a raster-order 8-bit grey stream
// a pixel is registered into the second stage, then pushed into the output queue, from which it can leave
// throughput: one pixel per cycle while req_stall is low, set by one line store read and one write per pixel
// reset: counters and row sum cleared, geometry 640 x 480, output queue emptied
// the line store is not cleared; the first row of every frame adds zero from above
module integral_image_stream
   import iis_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   // pixel channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [PIXEL_W-1:0]     req_pixel,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [AREA_W-1:0]      rsp_area_sum,
   output logic                   rsp_row_end,
   output logic                   rsp_frame_end,
   // register write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DIM_CFG_W-1:0]   csr_wdata
);

`include "integral_image_stream_assert.svh"

   // column and row counters only ever reach max-1
   localparam int COLW = $clog2(MAX_WIDTH);
   localparam int ROWW = $clog2(MAX_HEIGHT);
   // a whole row of 8-bit pixels fits here
   localparam int RUNW = PIXEL_W + COLW;
   localparam int PW   = QCNT_W + 1;

   localparam int WIDTH_RST  =
      (IMAGE_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : IMAGE_WIDTH_RESET;
   localparam int HEIGHT_RST =
      (IMAGE_HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : IMAGE_HEIGHT_RESET;

   // ---------------- configuration ----------------
   // geometry is stored as (size - 1) after clamping to 1..max
   logic [COLW-1:0] width_m1_ff, width_m1_in;
   logic [ROWW-1:0] height_m1_ff, height_m1_in;
   logic            csr_xfer;

   assign csr_ready = 1'b1;
   assign csr_xfer  = csr_valid && csr_ready;

   always_comb begin
      width_m1_in  = width_m1_ff;
      height_m1_in = height_m1_ff;
      if (csr_xfer) begin
         case (csr_index)
            REG_IMAGE_WIDTH: begin
               if (csr_wdata == '0) begin
                  width_m1_in = '0;
               end else if (32'(csr_wdata) > 32'(MAX_WIDTH)) begin
                  width_m1_in = COLW'(MAX_WIDTH - 1);
               end else begin
                  width_m1_in = COLW'(32'(csr_wdata) - 32'd1);
               end
            end
            REG_IMAGE_HEIGHT: begin
               if (csr_wdata == '0) begin
                  height_m1_in = '0;
               end else if (32'(csr_wdata) > 32'(MAX_HEIGHT)) begin
                  height_m1_in = ROWW'(MAX_HEIGHT - 1);
               end else begin
                  height_m1_in = ROWW'(32'(csr_wdata) - 32'd1);
               end
            end
            default: begin
               width_m1_in  = width_m1_ff;
               height_m1_in = height_m1_ff;
            end
         endcase
      end
   end

   // ---------------- front stage: scan position and row sum ----------------
   logic [COLW-1:0] col_ff, col_in;
   logic [ROWW-1:0] row_ff, row_in;
   logic [RUNW-1:0] run_ff, run_in;
   logic [RUNW-1:0] run_sum;
   logic            req_xfer;
   logic            last_col;
   logic            last_row;

   assign req_xfer = req_valid && !req_stall;
   // >= keeps a shrunken geometry from running the counters past the end
   assign last_col = (col_ff >= width_m1_ff);
   assign last_row = (row_ff >= height_m1_ff);
   assign run_sum  = run_ff + RUNW'(req_pixel);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      run_in = run_ff;
      if (req_xfer) begin
         if (last_col) begin
            col_in = '0;
            run_in = '0;
            row_in = last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
            run_in = run_sum;
         end
      end
   end

   // ---------------- second stage: add the row above, write back ----------------
   logic              s1_valid_ff;
   logic [COLW-1:0]   s1_col_ff;
   logic [RUNW-1:0]   s1_run_ff;
   logic              s1_first_row_ff;
   logic              s1_row_end_ff;
   logic              s1_frame_end_ff;
   logic              s1_fwd_ff;
   logic [AREA_W-1:0] s1_fwd_data_ff;
   logic              fwd_in;

   logic [AREA_W-1:0] store_rd_data;
   logic [AREA_W-1:0] above;
   logic [AREA_W-1:0] area;
   result_type        s1_result;

   // the previous pixel writes the column being read now (width of one):
   // the store returns the old value, so take the fresh sum instead
   assign fwd_in = s1_valid_ff && (s1_col_ff == col_ff);

   always_comb begin
      if (s1_first_row_ff) begin
         above = '0;
      end else if (s1_fwd_ff) begin
         above = s1_fwd_data_ff;
      end else begin
         above = store_rd_data;
      end
   end

   assign area = AREA_W'(s1_run_ff) + above;

   assign s1_result.area_sum  = area;
   assign s1_result.row_end   = s1_row_end_ff;
   assign s1_result.frame_end = s1_frame_end_ff;

   // line store of the previous row's area sums, one entry per column
   iis_ram #(
      .WIDTH (AREA_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (area),
      .rd_en   (req_xfer),
      .rd_addr (col_ff),
      .rd_data (store_rd_data)
   );

   // ---------------- output queue ----------------
   // every second-stage item enters the queue; the input stalls early
   // enough that the item in flight and the one behind it always fit
   result_type        q_data;
   logic [QCNT_W-1:0] q_count;
   logic [PW-1:0]     pending;

   iis_out_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_valid_ff),
      .push_data (s1_result),
      .out_valid (rsp_valid),
      .out_data  (q_data),
      .out_stall (rsp_stall),
      .count     (q_count)
   );

   assign pending   = PW'(q_count) + PW'(s1_valid_ff);
   assign req_stall = (pending > PW'(QUEUE_DEPTH - 2));

   assign rsp_area_sum  = q_data.area_sum;
   assign rsp_row_end   = q_data.row_end;
   assign rsp_frame_end = q_data.frame_end;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_col_ff       <= col_ff;
         s1_run_ff       <= run_sum;
         s1_first_row_ff <= (row_ff == '0);
         s1_row_end_ff   <= last_col;
         s1_frame_end_ff <= last_col && last_row;
         s1_fwd_ff       <= fwd_in;
         s1_fwd_data_ff  <= area;
      end
      if (reset) begin
         width_m1_ff  <= COLW'(WIDTH_RST - 1);
         height_m1_ff <= ROWW'(HEIGHT_RST - 1);
         col_ff       <= '0;
         row_ff       <= '0;
         run_ff       <= '0;
         s1_valid_ff  <= 1'b0;
      end else begin
         width_m1_ff  <= width_m1_in;
         height_m1_ff <= height_m1_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         run_ff       <= run_in;
         s1_valid_ff  <= req_xfer;
      end
   end

   // ---------------- checks ----------------
   `IIS_ASSERT_IMPL(a_queue_room, clock, reset, s1_valid_ff, q_count < QCNT_W'(QUEUE_DEPTH), "output queue overflow")
   `IIS_ASSERT_IMPL(a_frame_end_row_end, clock, reset, rsp_valid && rsp_frame_end, rsp_row_end, "frame end without row end")
   `IIS_ASSERT_NEXT(a_row_wrap, clock, reset, req_xfer && last_col, col_ff == '0 && run_ff == '0, "row did not restart")
   `IIS_ASSERT_IMPL(a_first_row_zero, clock, reset, s1_valid_ff && s1_first_row_ff, area == AREA_W'(s1_run_ff), "first row used the line store")

endmodule

// ===== tb/integral_image_stream_tb.sv =====
`timescale 1ns / 100ps

module integral_image_stream_tb
   import iis_pkg::*;
;

   // geometry limits of the instance under test
   localparam int LINE_MAX = 1024;
   localparam int ROWS_MAX = 1024;
   // pixels to send in all, the directed part included
   localparam int RUN_PIXELS = 1926;
   // cycles with no transfer on any channel before the run is given up
   localparam int IDLE_LIMIT = 1000;
   // settle time after the last result
   localparam int SETTLE_CYCLES = 4;

   // expected summed-area values, kept in step with every accepted pixel
   class area_sum_scoreboard;
      logic [AREA_W-1:0]    above_sums [LINE_MAX];
      logic [AREA_W-1:0]    row_sum;
      int unsigned          col_pos;
      int unsigned          row_pos;
      logic [DIM_CFG_W-1:0] width_reg;
      logic [DIM_CFG_W-1:0] height_reg;
      result_type           pending_sums [$];
      int unsigned          failures;

      function new();
         foreach (above_sums[i]) above_sums[i] = '0;
         row_sum    = '0;
         col_pos    = 0;
         row_pos    = 0;
         width_reg  = DIM_CFG_W'(IMAGE_WIDTH_RESET);
         height_reg = DIM_CFG_W'(IMAGE_HEIGHT_RESET);
         failures   = 0;
      endfunction

      // zero reads as one, anything past the limit saturates
      function int unsigned clamp_dim(logic [DIM_CFG_W-1:0] v, int unsigned limit);
         if (v == 0) return 1;
         if (v > limit) return limit;
         return v;
      endfunction

      function int unsigned eff_width();
         return clamp_dim(width_reg, LINE_MAX);
      endfunction

      function bit at_frame_start();
         return (col_pos == 0) && (row_pos == 0);
      endfunction

      function int unsigned pending_count();
         return pending_sums.size();
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [DIM_CFG_W-1:0] value);
         case (index)
            REG_IMAGE_WIDTH: width_reg = value;
            REG_IMAGE_HEIGHT: height_reg = value;
            default: ;
         endcase
      endfunction

      // one pixel in: running row sum plus the same column one row up
      function void take_pixel(logic [PIXEL_W-1:0] pixel);
         int unsigned       w;
         int unsigned       h;
         int unsigned       col;
         logic [AREA_W-1:0] above;
         result_type        r;
         w   = clamp_dim(width_reg, LINE_MAX);
         h   = clamp_dim(height_reg, ROWS_MAX);
         col = (col_pos >= LINE_MAX) ? LINE_MAX - 1 : col_pos;
         row_sum = row_sum + pixel;
         above = (row_pos != 0) ? above_sums[col] : '0;
         r.area_sum = row_sum + above;
         above_sums[col] = r.area_sum;
         r.row_end   = (col_pos + 1 >= w);
         r.frame_end = r.row_end && (row_pos + 1 >= h);
         pending_sums.push_back(r);
         if (r.row_end) begin
            col_pos = 0;
            row_sum = '0;
            row_pos = r.frame_end ? 0 : row_pos + 1;
         end else begin
            col_pos++;
         end
      endfunction

      function void match_result(logic [AREA_W-1:0] area_sum, logic row_end, logic frame_end);
         result_type want;
         if (pending_sums.size() == 0) begin
            $error("result with no pixel outstanding: area_sum %0d", area_sum);
            failures++;
            return;
         end
         want = pending_sums.pop_front();
         if (area_sum !== want.area_sum) begin
            $error("area_sum mismatch: expected %0d, actual %0d", want.area_sum, area_sum);
            failures++;
         end
         if (row_end !== want.row_end) begin
            $error("row_end mismatch: expected %0b, actual %0b", want.row_end, row_end);
            failures++;
         end
         if (frame_end !== want.frame_end) begin
            $error("frame_end mismatch: expected %0b, actual %0b", want.frame_end, frame_end);
            failures++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [PIXEL_W-1:0]     req_pixel = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [AREA_W-1:0]      rsp_area_sum;
   logic                   rsp_row_end;
   logic                   rsp_frame_end;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [DIM_CFG_W-1:0]   csr_wdata = '0;

   area_sum_scoreboard area_board = new();

   // sender state: burst bookkeeping and pixel count
   int burst_left  = 0;
   bit gapless     = 1'b0;
   int pixels_sent = 0;

   // receiver stall pattern state
   int stall_run    = 0;
   int stall_pct    = 0;
   int pattern_left = 0;

   int idle_cycles = 0;

   integral_image_stream #(
      .MAX_WIDTH  (LINE_MAX),
      .MAX_HEIGHT (ROWS_MAX)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_pixel     (req_pixel),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_area_sum  (rsp_area_sum),
      .rsp_row_end   (rsp_row_end),
      .rsp_frame_end (rsp_frame_end),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // receiver: stall runs of random length, odds re-drawn whenever a pattern runs out,
   // one setting of the odds never stalls at all
   always @(posedge clock) begin
      if (stall_run != 0) begin
         rsp_stall <= 1'b1;
         stall_run <= stall_run - 1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         rsp_stall <= 1'b1;
         stall_run <= $urandom_range(0, 11);
      end else begin
         rsp_stall <= 1'b0;
      end
      if (pattern_left == 0) begin
         pattern_left <= $urandom_range(32, 256);
         case ($urandom_range(0, 3))
            0: stall_pct <= 0;
            1: stall_pct <= 10;
            2: stall_pct <= 30;
            default: stall_pct <= 60;
         endcase
      end else begin
         pattern_left <= pattern_left - 1;
      end
   end

   // result check and watchdog, sampled on the edge where the transfer happens
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_valid && !rsp_stall)
            area_board.match_result(rsp_area_sum, rsp_row_end, rsp_frame_end);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // one pixel transfer; valid stays high inside a burst, a gap may come before it
   task automatic feed_pixel(input logic [PIXEL_W-1:0] value);
      int gap;
      if (burst_left == 0) begin
         gap = gapless ? 0 : $urandom_range(0, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_pixel <= value;
      do @(posedge clock); while (req_stall);
      area_board.take_pixel(value);
      pixels_sent++;
   endtask

   // extremes come up often, the rest is uniform
   task automatic feed_random(input int count);
      logic [PIXEL_W-1:0] value;
      repeat (count) begin
         case ($urandom_range(0, 7))
            0: value = '0;
            1: value = '1;
            default: value = PIXEL_W'($urandom_range(0, 255));
         endcase
         feed_pixel(value);
      end
   endtask

   task automatic finish_frame();
      while (!area_board.at_frame_start()) feed_random(1);
   endtask

   // hold the pixel side until every result is back, then let the pipe settle
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (area_board.pending_count() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register writes only ever land on an idle block
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [DIM_CFG_W-1:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      area_board.write_reg(index, value);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [DIM_CFG_W-1:0] next_width;
      logic [DIM_CFG_W-1:0] next_height;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // two pixels at the reset geometry, no row end that early in a 640 row
      feed_pixel(8'd0);
      feed_pixel(8'd255);
      // shrink to 3 x 2 mid-row: third pixel closes row 0, then one full row
      write_csr(REG_IMAGE_WIDTH, 11'd3);
      write_csr(REG_IMAGE_HEIGHT, 11'd2);
      feed_pixel(8'd255);
      feed_pixel(8'd255);
      feed_pixel(8'd0);
      feed_pixel(8'd128);
      // zero width and height read as one: every pixel is its own frame
      write_csr(REG_IMAGE_WIDTH, 11'd0);
      write_csr(REG_IMAGE_HEIGHT, 11'd0);
      feed_pixel(8'd255);
      feed_pixel(8'd0);
      feed_pixel(8'd1);
      // single column, three rows of full-scale pixels
      write_csr(REG_IMAGE_WIDTH, 11'd1);
      write_csr(REG_IMAGE_HEIGHT, 11'd3);
      repeat (3) feed_pixel(8'd255);
      // height past the limit, then cut short inside row 1
      write_csr(REG_IMAGE_WIDTH, 11'd4);
      write_csr(REG_IMAGE_HEIGHT, 11'd2047);
      feed_random(6);
      write_csr(REG_IMAGE_HEIGHT, 11'd2);
      feed_random(2);
      // width shrinks below the column already reached: row ends at once
      feed_random(3);
      write_csr(REG_IMAGE_WIDTH, 11'd2);
      feed_random(3);

      // one full-width row with the width register past the limit;
      // this also fills every line store entry before any mid-frame writes
      gapless = 1'b1;
      write_csr(REG_IMAGE_WIDTH, DIM_CFG_W'($urandom_range(LINE_MAX + 1, 2047)));
      write_csr(REG_IMAGE_HEIGHT, DIM_CFG_W'($urandom_range(0, 1)));
      finish_frame();
      feed_random(1);
      finish_frame();

      // random geometries: mostly whole frames, some broken by a register write
      while (pixels_sent < RUN_PIXELS) begin
         gapless = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 9))
            0: next_width = '0;
            1, 2: next_width = DIM_CFG_W'($urandom_range(17, 48));
            default: next_width = DIM_CFG_W'($urandom_range(1, 16));
         endcase
         case ($urandom_range(0, 9))
            0: next_height = '0;
            1: next_height = DIM_CFG_W'($urandom_range(ROWS_MAX + 1, 2047));
            default: next_height = DIM_CFG_W'($urandom_range(1, 6));
         endcase
         write_csr(REG_IMAGE_WIDTH, next_width);
         write_csr(REG_IMAGE_HEIGHT, next_height);
         if (next_height > ROWS_MAX || $urandom_range(0, 3) == 0) begin
            // up to three rows in, then change geometry under the running counters
            feed_random($urandom_range(1, 3 * area_board.eff_width()));
            if (next_height > ROWS_MAX)
               write_csr(REG_IMAGE_HEIGHT, DIM_CFG_W'($urandom_range(1, 4)));
            else if ($urandom_range(0, 1) == 0)
               write_csr(REG_IMAGE_WIDTH, DIM_CFG_W'($urandom_range(0, 16)));
            else
               write_csr(REG_IMAGE_HEIGHT, DIM_CFG_W'($urandom_range(0, 4)));
            finish_frame();
         end
         repeat ($urandom_range(1, 3)) begin
            feed_random(1);
            finish_frame();
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (area_board.failures == 0 && area_board.pending_count() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
